@@ hw/rtl/ucssd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucssd_pkg
// Shared types, constants and decode functions for the UART command
// seven-segment display controller.
// ----------------------------------------------------------------------------
package ucssd_pkg;

  localparam int CMD_BUF_DEPTH = 16;
  localparam int NUM_DIGITS    = 8;

  localparam int BUF_AW = $clog2(CMD_BUF_DEPTH);
  localparam int CNT_W  = $clog2(CMD_BUF_DEPTH + 1);
  localparam int DIG_AW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int POS_W  = $clog2(NUM_DIGITS + 1);

  localparam int REPLY_LEN = 4;
  localparam int REPLY_W   = $clog2(REPLY_LEN);

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_O       = 8'h4F;
  localparam logic [7:0] CH_K       = 8'h4B;
  localparam logic [7:0] CMD_NUMBER = 8'h4E;  // 'N'
  localparam logic [7:0] CMD_CLEAR  = 8'h43;  // 'C'
  localparam logic [7:0] CMD_ACK    = 8'h41;  // 'A'

  localparam logic [3:0] BLANK_CODE = 4'hA;
  localparam logic [7:0] SEG_BLANK  = 8'hFF;

  localparam logic OP_RX     = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] digit_select;
    logic [7:0] segments;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECODE,
    ST_FIND,
    ST_LOAD,
    ST_REPLY
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic store_byte;       // append received byte to the line buffer
    logic blank;            // blank every digit
    logic walk_from_count;  // point the walk at the last stored byte
    logic walk_dec;         // step the walk one byte down
    logic pos_clear;        // restart the digit position at zero
    logic load_step;        // copy one converted character into the digits
    logic emit_scan;        // load a scan result into the output register
    logic emit_reply;       // load the next reply byte into the output register
    logic clear_line;       // drop the buffered line
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic in_is_tick;
    logic in_is_lf;
    logic cmd_number;
    logic cmd_clear;
    logic cmd_ack;
    logic walk_zero;
    logic walk_is_cr;
    logic load_done;
    logic reply_last;
  } dp_status_t;

  function automatic logic [7:0] seg_decode(input logic [3:0] v);
    logic [7:0] s;
    case (v)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h98;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] char_to_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      return d[3:0];
    end
    return BLANK_CODE;
  endfunction

  function automatic logic [7:0] reply_char(input logic [REPLY_W-1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = CH_O;
      2'd1:    c = CH_K;
      2'd2:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/ucssd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucssd_datapath
// Line buffer, digit store, scan ring, copy walk and output register.
// ----------------------------------------------------------------------------
module ucssd_datapath import ucssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [7:0]        cmd_buf_r [CMD_BUF_DEPTH];
  logic [CNT_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [BUF_AW-1:0] walk_r, walk_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        digit_r [NUM_DIGITS];
  logic [3:0]        digit_nxt [NUM_DIGITS];
  logic [DIG_AW-1:0] scan_r, scan_nxt;
  logic [REPLY_W-1:0] reply_r, reply_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              buf_full;
  logic [BUF_AW-1:0] last_idx;
  logic [7:0]        walk_char;
  logic [7:0]        scan_onehot;

  assign buf_full    = (wr_idx_r == CNT_W'(CMD_BUF_DEPTH));
  assign last_idx    = BUF_AW'(wr_idx_r - CNT_W'(1));
  assign walk_char   = cmd_buf_r[walk_r];
  assign scan_onehot = 8'(1) << scan_r;

  // Buffer entries past the fill count are never read, so no clearing.
  always_ff @(posedge clk) begin
    if (cmd.store_byte && !buf_full) begin
      cmd_buf_r[wr_idx_r[BUF_AW-1:0]] <= in_data.rx_byte;
    end
  end

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    if (cmd.clear_line) begin
      wr_idx_nxt = '0;
    end else if (cmd.store_byte && !buf_full) begin
      wr_idx_nxt = wr_idx_r + CNT_W'(1);
    end

    walk_nxt = walk_r;
    if (cmd.walk_from_count) begin
      walk_nxt = last_idx;
    end else if (cmd.walk_dec || cmd.load_step) begin
      walk_nxt = walk_r - BUF_AW'(1);
    end

    pos_nxt = pos_r;
    if (cmd.pos_clear) begin
      pos_nxt = '0;
    end else if (cmd.load_step) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    for (int i = 0; i < NUM_DIGITS; i++) begin
      digit_nxt[i] = cmd.blank ? BLANK_CODE : digit_r[i];
      if (cmd.load_step && (pos_r == POS_W'(i))) begin
        digit_nxt[i] = char_to_digit(walk_char);
      end
    end

    scan_nxt = scan_r;
    if (cmd.emit_scan) begin
      scan_nxt = (scan_r == DIG_AW'(NUM_DIGITS - 1)) ? '0 : scan_r + DIG_AW'(1);
    end

    reply_nxt = cmd.emit_reply ? reply_r + REPLY_W'(1) : reply_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (cmd.emit_scan) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = KIND_SCAN;
      out_nxt.digit_select = scan_onehot;
      out_nxt.segments     = seg_decode(digit_r[scan_r]);
      out_nxt.tx_byte      = '0;
      out_nxt.last         = 1'b1;
    end else if (cmd.emit_reply) begin
      out_valid_nxt        = 1'b1;
      out_nxt.kind         = KIND_TX;
      out_nxt.digit_select = '0;
      out_nxt.segments     = '0;
      out_nxt.tx_byte      = reply_char(reply_r);
      out_nxt.last         = (reply_r == REPLY_W'(REPLY_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      walk_r      <= '0;
      pos_r       <= '0;
      scan_r      <= '0;
      reply_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_r[i] <= 4'(i);
      end
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      walk_r      <= walk_nxt;
      pos_r       <= pos_nxt;
      scan_r      <= scan_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign status.slot_free  = !out_valid_r || out_ready;
  assign status.in_is_tick = (in_data.opcode == OP_TICK);
  assign status.in_is_lf   = (in_data.rx_byte == CH_LF);
  assign status.cmd_number = (wr_idx_r != '0) && (cmd_buf_r[0] == CMD_NUMBER);
  assign status.cmd_clear  = (wr_idx_r != '0) && (cmd_buf_r[0] == CMD_CLEAR);
  assign status.cmd_ack    = (wr_idx_r != '0) && (cmd_buf_r[0] == CMD_ACK);
  assign status.walk_zero  = (walk_r == '0);
  assign status.walk_is_cr = (walk_char == CH_CR);
  assign status.load_done  = (walk_r == '0) || (pos_r == POS_W'(NUM_DIGITS));
  assign status.reply_last = (reply_r == REPLY_W'(REPLY_LEN - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/ucssd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucssd_ctrl
// Sequencer for scan ticks, line decode, digit copy walk and OK reply.
// ----------------------------------------------------------------------------
module ucssd_ctrl import ucssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.in_is_tick) begin
            state_nxt = ST_SCAN;
          end else if (status.in_is_lf) begin
            state_nxt = ST_DECODE;
          end else begin
            cmd.store_byte = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.slot_free) begin
          cmd.emit_scan = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DECODE: begin
        if (status.cmd_number) begin
          cmd.walk_from_count = 1'b1;
          state_nxt           = ST_FIND;
        end else if (status.cmd_clear) begin
          cmd.blank = 1'b1;
          state_nxt = ST_REPLY;
        end else if (status.cmd_ack) begin
          state_nxt = ST_REPLY;
        end else begin
          cmd.clear_line = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FIND: begin
        // Search down for the last CR; the span ends there or at the LF.
        if (status.walk_zero) begin
          cmd.blank           = 1'b1;
          cmd.pos_clear       = 1'b1;
          cmd.walk_from_count = 1'b1;
          state_nxt           = ST_LOAD;
        end else if (status.walk_is_cr) begin
          cmd.blank     = 1'b1;
          cmd.pos_clear = 1'b1;
          cmd.walk_dec  = 1'b1;
          state_nxt     = ST_LOAD;
        end else begin
          cmd.walk_dec = 1'b1;
        end
      end
      ST_LOAD: begin
        if (status.load_done) begin
          state_nxt = ST_REPLY;
        end else begin
          cmd.load_step = 1'b1;
        end
      end
      ST_REPLY: begin
        if (status.slot_free) begin
          cmd.emit_reply = 1'b1;
          if (status.reply_last) begin
            cmd.clear_line = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/uart_command_seven_segment_display.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_seven_segment_display
// Eight-digit multiplexed seven-segment controller driven by UART lines.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): each transaction is either a
//   received UART byte (opcode 0) or a display scan tick (opcode 1).
// Output channel (out_valid/out_ready/out_data): scan results (kind 0) with a
//   one-hot digit select and active-low segments, or reply bytes (kind 1).
// Sequencing:
//   - plain byte: stored in the accept cycle; the sequencer stays idle.
//   - scan tick: the scan state loads the result into the output register
//     once the output slot is free, then the sequencer returns to idle.
//   - LF: a decode state, then for 'N' a CR search walk down the line
//     buffer and a digit copy walk, then the four reply bytes. The walks
//     read the line buffer one entry a cycle.
// in_ready is high only while the sequencer is idle; it stays high while a
//   finished result waits in the output register.
// Reset: line buffer empty, digit i shows i, scan starts at position 0.
// Receiver stall: the output register holds its transaction and the
//   sequencer waits before loading the next scan or reply byte.
// ----------------------------------------------------------------------------
module uart_command_seven_segment_display import ucssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence scans, line decode, digit load and reply.
  ucssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold line buffer, digits, scan ring and output register.
  ucssd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Scan results drive exactly one digit and always end their transaction.
  a_scan_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_SCAN) |->
      ($onehot(out_data.digit_select) && out_data.last && out_data.tx_byte == 8'h00))
    else $error("scan result malformed");

  // Reply bytes leave the display fields at zero.
  a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_TX) |->
      (out_data.digit_select == 8'h00 && out_data.segments == 8'h00))
    else $error("reply result carries display fields");

  // Only the closing LF of "OK\r\n" carries last.
  a_tx_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_TX) |->
      (out_data.last == (out_data.tx_byte == CH_LF)))
    else $error("reply last flag misplaced");

  // A tick is worked on alone: input closes right after it is taken.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == OP_TICK) |=> !in_ready)
    else $error("input accepted during scan");

  // A new scan result appears only after a tick was taken.
  a_scan_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && out_data.kind == KIND_SCAN) |->
      $past(!in_ready, 1))
    else $error("scan result without tick");

endmodule

@@ bench/uart_command_seven_segment_display_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_command_seven_segment_display_test
// Self-checking bench for the UART command seven-segment display controller.
// ----------------------------------------------------------------------------
// A directed stimulus table covers the reset display, every command, the
// empty line, an unknown command and the byte extremes. Random command lines
// and scan ticks follow. Every accepted transaction runs through a local
// display predictor, and each result is compared field by field with the
// oldest predicted result. Both channels idle at random in the first two of three phases.
// One phase opens with a long receiver hold-off, and the sender drains all
// pending results between phases.
// ----------------------------------------------------------------------------
module uart_command_seven_segment_display_test;
  import ucssd_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
  localparam int HOLD_OFF      = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 40;    // wait after the final drain for stray results
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 400;

  // Active-low patterns for digits 0..9; anything else shows blank.
  localparam logic [7:0] SEG_LUT [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h98
  };
  localparam logic [7:0] REPLY_TEXT [REPLY_LEN] = '{CH_O, CH_K, CH_CR, CH_LF};
  localparam logic [7:0] CH_UNKNOWN_CMD = 8'h58;  // 'X', not a command

  typedef struct packed {
    in_item_t  stim;
    logic      typed;  // want holds a result read off the reset state
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predictor state
  logic [7:0] line_buf [CMD_BUF_DEPTH];
  int         line_len;
  logic [3:0] shown_digit [NUM_DIGITS];
  int         scan_at;

  out_item_t  pending_results [$];
  out_item_t  oldest_result;
  dir_row_t   directed_rows [DIRECTED_ROWS];

  int error_count;
  int items_sent;
  int send_idle_pct;
  int rcv_idle_pct;
  int rcv_hold;
  int stall_cycles;

  uart_command_seven_segment_display dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Display predictor: advance the local copy of the controller by one
  // accepted transaction and queue every result it causes.
  // --------------------------------------------------------------------------
  function automatic void predict_display(input in_item_t item);
    out_item_t  r;
    logic [7:0] cmd;
    logic [7:0] c;
    logic       known;
    int         span_end;
    int         pos;

    r = '0;
    if (item.opcode == OP_TICK) begin
      // Drive the current position, then advance the scan ring.
      r.kind         = KIND_SCAN;
      r.digit_select = 8'(1 << scan_at);
      r.segments     = (shown_digit[scan_at] < 10) ? SEG_LUT[shown_digit[scan_at]] : 8'hFF;
      r.last         = 1'b1;
      pending_results.push_back(r);
      scan_at = (scan_at + 1) % NUM_DIGITS;
      return;
    end

    if (item.rx_byte != CH_LF) begin
      // Append to the line; drop the byte once the buffer is full.
      if (line_len < CMD_BUF_DEPTH) begin
        line_buf[line_len] = item.rx_byte;
        line_len++;
      end
      return;
    end

    // LF: act on the first byte of the line; an empty line is unknown.
    cmd   = (line_len > 0) ? line_buf[0] : CH_LF;
    known = 1'b1;
    case (cmd)
      CMD_NUMBER: begin
        // The span ends at the last CR after the command byte, else at LF.
        span_end = line_len;
        for (int k = 1; k < line_len; k++) begin
          if (line_buf[k] == CH_CR) begin
            span_end = k;
          end
        end
        for (int k = 0; k < NUM_DIGITS; k++) begin
          shown_digit[k] = BLANK_CODE;
        end
        // Last character lands in position 0; drop the earliest of a long span.
        for (int k = 1; k < span_end; k++) begin
          pos = span_end - 1 - k;
          c   = line_buf[k];
          if (pos < NUM_DIGITS) begin
            shown_digit[pos] = (c >= CH_ZERO && c <= CH_NINE) ? 4'(c - CH_ZERO) : BLANK_CODE;
          end
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          shown_digit[k] = BLANK_CODE;
        end
      end
      CMD_ACK: begin
      end
      default: begin
        known = 1'b0;
      end
    endcase

    for (int k = 0; k < CMD_BUF_DEPTH; k++) begin
      line_buf[k] = 8'h00;
    end
    line_len = 0;

    if (known) begin
      for (int k = 0; k < REPLY_LEN; k++) begin
        r         = '0;
        r.kind    = KIND_TX;
        r.tx_byte = REPLY_TEXT[k];
        r.last    = (k == REPLY_LEN - 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_LF) begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  function automatic dir_row_t rx_row(input logic [7:0] b);
    dir_row_t row;
    row              = '0;
    row.stim.opcode  = OP_RX;
    row.stim.rx_byte = b;
    return row;
  endfunction

  function automatic dir_row_t tick_row();
    dir_row_t row;
    row              = '0;
    row.stim.opcode  = OP_TICK;
    row.stim.rx_byte = 8'hFF;
    return row;
  endfunction

  // Scan tick right after reset: position p shows digit p.
  function automatic dir_row_t reset_scan_row(input int p, input logic [7:0] seg);
    dir_row_t row;
    row                   = '0;
    row.stim.opcode       = OP_TICK;
    row.stim.rx_byte      = p[0] ? 8'hFF : 8'h00;
    row.typed             = 1'b1;
    row.want.kind         = KIND_SCAN;
    row.want.digit_select = 8'(1 << p);
    row.want.segments     = seg;
    row.want.last         = 1'b1;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    end
  endtask

  // Offer one transaction: idle first at random, hold valid until accepted,
  // then predict at the accepting edge.
  task automatic offer(input in_item_t item);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_display(item);
    items_sent++;
  endtask

  // Mostly well-formed command lines with random content, some raw noise.
  // Scan ticks fall between the bytes at random.
  task automatic send_random_line();
    logic [7:0] line_bytes [$];
    in_item_t   stim;
    int         pick;
    int         len;

    pick = $urandom_range(99);
    if (pick < 10) begin
      len = $urandom_range(1, 6);
      repeat (len) line_bytes.push_back(8'($urandom_range(255)));
    end else begin
      if (pick < 50) begin
        line_bytes.push_back(CMD_NUMBER);
      end else if (pick < 62) begin
        line_bytes.push_back(CMD_CLEAR);
      end else if (pick < 74) begin
        line_bytes.push_back(CMD_ACK);
      end else if (pick >= 84) begin
        line_bytes.push_back(any_but_lf());
      end
      if (line_bytes.size() != 0 && line_bytes[0] == CMD_NUMBER) begin
        // Mostly spans that fit, some long enough to overflow the buffer.
        len = ($urandom_range(4) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        repeat (len) begin
          line_bytes.push_back(($urandom_range(4) == 0) ? any_but_lf()
                                                        : 8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(9) < 7) begin
          line_bytes.push_back(CH_CR);
        end
      end
      // Trailing bytes, often a CR, so that a later CR moves the span end.
      if (line_bytes.size() != 0 && $urandom_range(3) == 0) begin
        len = $urandom_range(1, 3);
        repeat (len) line_bytes.push_back($urandom_range(1) ? CH_CR : any_but_lf());
      end
      line_bytes.push_back(CH_LF);
    end

    foreach (line_bytes[i]) begin
      if ($urandom_range(3) == 0) begin
        stim.opcode  = OP_TICK;
        stim.rx_byte = 8'($urandom_range(255));
        offer(stim);
      end
      stim.opcode  = OP_RX;
      stim.rx_byte = line_bytes[i];
      offer(stim);
    end
  endtask

  // Pause the sender until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: a long hold-off when asked, otherwise random stalls.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_ready <= 1'b0;
      rcv_hold  = rcv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest predicted one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("kind", 8'(out_data.kind), 8'(oldest_result.kind));
        check_field("digit_select", out_data.digit_select, oldest_result.digit_select);
        check_field("segments", out_data.segments, oldest_result.segments);
        check_field("tx_byte", out_data.tx_byte, oldest_result.tx_byte);
        check_field("last", 8'(out_data.last), 8'(oldest_result.last));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    stall_cycles  = 0;
    rcv_hold      = 0;
    send_idle_pct = 28;
    rcv_idle_pct  = 69;

    // Reset state of the predictor: empty line, digit i shows i.
    for (int k = 0; k < CMD_BUF_DEPTH; k++) begin
      line_buf[k] = 8'h00;
    end
    for (int k = 0; k < NUM_DIGITS; k++) begin
      shown_digit[k] = 4'(k);
    end
    line_len = 0;
    scan_at  = 0;

    directed_rows = '{
      // walk the full scan ring straight out of reset
      reset_scan_row(0, 8'hC0), reset_scan_row(1, 8'hF9),
      reset_scan_row(2, 8'hA4), reset_scan_row(3, 8'hB0),
      reset_scan_row(4, 8'h99), reset_scan_row(5, 8'h92),
      reset_scan_row(6, 8'h82), reset_scan_row(7, 8'hF8),
      // acknowledge only
      rx_row(CMD_ACK), rx_row(CH_LF),
      // empty line, then an unknown command: no reply
      rx_row(CH_LF),
      rx_row(CH_UNKNOWN_CMD), rx_row(CH_LF),
      // number with a non-digit, a CR and a byte after the CR
      rx_row(CMD_NUMBER), rx_row(CH_NINE), rx_row(8'hFF), rx_row(CH_ZERO),
      rx_row(CH_CR), rx_row(8'h00), rx_row(CH_LF),
      tick_row(),
      // clear, then scan blank positions
      rx_row(CMD_CLEAR), rx_row(CH_LF),
      tick_row(), tick_row()
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles lightly, receiver heavily.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].stim);
      // Replace the predicted scan result with the one read off reset.
      if (directed_rows[i].typed) begin
        pending_results[pending_results.size() - 1] = directed_rows[i].want;
      end
    end
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS / 6) begin
      send_random_line();
    end
    drain_results();
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS / 3) begin
      send_random_line();
    end
    drain_results();

    // Phase two: roles swapped; hold the receiver off so the block backs up.
    send_idle_pct = 69;
    rcv_idle_pct  = 28;
    rcv_hold      = HOLD_OFF;
    while (items_sent < DIRECTED_ROWS + (2 * RANDOM_ITEMS) / 3) begin
      send_random_line();
    end
    drain_results();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      send_random_line();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
